// File: rtl/core/mx2_pkg.sv
// ----------------------------------------------------------------------------
// mx2_pkg
// Shared types and codes of the 2x2 matrix coprocessor.
// ----------------------------------------------------------------------------
package mx2_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned NumWords = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef word_t [3:0]      quad_t;

  // operation codes held in the operation word
  localparam word_t OP_ADD       = 32'h0000_000b;
  localparam word_t OP_SUB       = 32'h0000_000c;
  localparam word_t OP_MUL       = 32'h0000_000d;
  localparam word_t OP_TRANSPOSE = 32'h0000_000e;
  localparam word_t OP_DET       = 32'h0000_000f;

  // status handshake codes
  localparam word_t START_CODE   = 32'h0000_0002;
  localparam word_t DONE_CODE    = 32'h0000_0004;

  // word map
  localparam addr_t ADDR_A0      = 4'd0;
  localparam addr_t ADDR_B0      = 4'd4;
  localparam addr_t ADDR_RES0    = 4'd8;
  localparam addr_t ADDR_DET     = 4'd12;
  localparam addr_t ADDR_OP      = 4'd14;
  localparam addr_t ADDR_STATUS  = 4'd15;

  typedef struct packed {
    logic  is_write;
    addr_t addr;
    word_t wdata;
  } mx2_access_t;

  typedef struct packed {
    logic  quad_we;
    logic  det_we;
    quad_t quad;
    word_t det;
  } mx2_alu_res_t;

endpackage

// File: rtl/core/mx2_alu.sv
// ----------------------------------------------------------------------------
// mx2_alu
// Matrix arithmetic: add, subtract and product of the A and B operands,
// transpose and determinant of A, all modulo 2^32.
// ----------------------------------------------------------------------------
module mx2_alu
  import mx2_pkg::*;
(
  input  quad_t        mat_a,
  input  quad_t        mat_b,
  input  word_t        op,
  output mx2_alu_res_t res
);

  // low halves of the products
  word_t p_a0b0, p_a1b2, p_a0b1, p_a1b3;
  word_t p_a2b0, p_a3b2, p_a2b1, p_a3b3;
  word_t p_a0a3, p_a1a2;

  assign p_a0b0 = mat_a[0] * mat_b[0];
  assign p_a1b2 = mat_a[1] * mat_b[2];
  assign p_a0b1 = mat_a[0] * mat_b[1];
  assign p_a1b3 = mat_a[1] * mat_b[3];
  assign p_a2b0 = mat_a[2] * mat_b[0];
  assign p_a3b2 = mat_a[3] * mat_b[2];
  assign p_a2b1 = mat_a[2] * mat_b[1];
  assign p_a3b3 = mat_a[3] * mat_b[3];
  assign p_a0a3 = mat_a[0] * mat_a[3];
  assign p_a1a2 = mat_a[1] * mat_a[2];

  always_comb begin
    res.quad_we = 1'b0;
    res.det_we  = 1'b0;
    res.quad    = '0;
    res.det     = p_a0a3 - p_a1a2;
    if (op == OP_ADD) begin
      res.quad_we = 1'b1;
      for (int i = 0; i < 4; i++) begin
        res.quad[i] = mat_a[i] + mat_b[i];
      end
    end else if (op == OP_SUB) begin
      res.quad_we = 1'b1;
      for (int i = 0; i < 4; i++) begin
        res.quad[i] = mat_a[i] - mat_b[i];
      end
    end else if (op == OP_MUL) begin
      res.quad_we = 1'b1;
      res.quad[0] = p_a0b0 + p_a1b2;
      res.quad[1] = p_a0b1 + p_a1b3;
      res.quad[2] = p_a2b0 + p_a3b2;
      res.quad[3] = p_a2b1 + p_a3b3;
    end else if (op == OP_TRANSPOSE) begin
      res.quad_we = 1'b1;
      res.quad[0] = mat_a[0];
      res.quad[1] = mat_a[2];
      res.quad[2] = mat_a[1];
      res.quad[3] = mat_a[3];
    end else if (op == OP_DET) begin
      res.det_we  = 1'b1;
    end
  end

endmodule

// File: rtl/core/mx2_regfile.sv
// ----------------------------------------------------------------------------
// mx2_regfile
// Sixteen-word register file: bus reads and writes, start handling and
// result write-back from the ALU.
// ----------------------------------------------------------------------------
module mx2_regfile
  import mx2_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         exec_en,
  input  mx2_access_t  acc,
  input  mx2_alu_res_t alu_res,
  output word_t        rdata,
  output quad_t        mat_a,
  output quad_t        mat_b,
  output word_t        op
);

  word_t word_r   [NumWords];
  word_t word_nxt [NumWords];
  logic  start;

  assign start = acc.is_write && (acc.addr == ADDR_STATUS) && (acc.wdata == START_CODE);
  assign rdata = word_r[acc.addr];
  assign op    = word_r[ADDR_OP];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mat_a[i] = word_r[ADDR_A0 + addr_t'(i)];
      mat_b[i] = word_r[ADDR_B0 + addr_t'(i)];
    end
  end

  always_comb begin
    word_nxt = word_r;
    if (exec_en && acc.is_write) begin
      if (start) begin
        if (alu_res.quad_we) begin
          for (int i = 0; i < 4; i++) begin
            word_nxt[ADDR_RES0 + addr_t'(i)] = alu_res.quad[i];
          end
        end
        if (alu_res.det_we) begin
          word_nxt[ADDR_DET] = alu_res.det;
        end
        word_nxt[ADDR_STATUS] = DONE_CODE;
      end else begin
        word_nxt[acc.addr] = acc.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumWords; i++) begin
        word_r[i] <= '0;
      end
    end else begin
      word_r <= word_nxt;
    end
  end

endmodule

// File: rtl/core/matrix2x2_register_coprocessor.sv
// ----------------------------------------------------------------------------
// matrix2x2_register_coprocessor
// 2x2 matrix coprocessor behind a 16-word register file.
// ----------------------------------------------------------------------------
// Each item is one bus access. A read returns the addressed word; a write
// stores a word and returns zero. Words 0-3 hold A, 4-7 hold B (row-major),
// word 14 the operation, word 15 the status. Writing 2 to word 15 runs the
// operation in the same cycle and leaves 4 there. An item is registered at
// the input, executed against the register file once the output register
// can take its result, and that result lands in the output register. The
// coprocessor takes one item per cycle while the result side keeps taking.
// Execution holds the ten parallel 32x32 products of the matrix product and
// determinant.
// ----------------------------------------------------------------------------
module matrix2x2_register_coprocessor
  import mx2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_word_address,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_value
);

  logic         in_valid_r;
  mx2_access_t  acc_r;
  logic         out_valid_r;
  word_t        out_data_r;
  logic         advance;

  word_t        rdata;
  quad_t        mat_a;
  quad_t        mat_b;
  word_t        op;
  mx2_alu_res_t alu_res;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      acc_r.is_write <= in_command;
      acc_r.addr     <= in_word_address;
      acc_r.wdata    <= in_write_value;
    end
  end

  mx2_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (advance),
    .acc     (acc_r),
    .alu_res (alu_res),
    .rdata   (rdata),
    .mat_a   (mat_a),
    .mat_b   (mat_b),
    .op      (op)
  );

  mx2_alu u_alu (
    .mat_a (mat_a),
    .mat_b (mat_b),
    .op    (op),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= acc_r.is_write ? '0 : rdata;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

endmodule
